/* sv/bsm_pkg.sv */
// Shared types and constants of the bank switch mapper.
package bsm_pkg;

   typedef enum logic [1:0] {
      OP_CPU_WRITE = 2'd0,
      OP_PROT_READ = 2'd1,
      OP_PRG_FETCH = 2'd2,
      OP_CHR_FETCH = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  open_bus;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [8:0]  mapped_bank;
      logic [20:0] mapped_address;
      logic        mirror_mode;
   } rsp_word_type;

   // Configuration register indexes.
   localparam logic CSR_PRG_BANK_MASK = 1'b0;
   localparam logic CSR_CHR_BANK_MASK = 1'b1;

   localparam logic [7:0] PRG_MASK_RESET = 8'd15;
   localparam logic [8:0] CHR_MASK_RESET = 9'd255;

   // Write decode on address bits 15, 14, 13 and 0.
   localparam logic [3:0] WR_COMMAND  = 4'b1000;
   localparam logic [3:0] WR_BANK     = 4'b1001;
   localparam logic [3:0] WR_MIRRORING = 4'b1010;

   // Fixed program banks and the protection window (address bits 15..11).
   localparam logic [7:0] PRG_BANK_SECOND_LAST = 8'hFE;
   localparam logic [7:0] PRG_BANK_LAST        = 8'hFF;
   localparam logic [4:0] PROT_WINDOW          = 5'b01011;

endpackage

/* sv/bsm_channels.sv */
// Valid/ready channel interfaces for the request and response words.
interface bsm_req_if;
   logic                  valid;
   logic                  ready;
   bsm_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bsm_rsp_if;
   logic                  valid;
   logic                  ready;
   bsm_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/bank_switch_mapper_with_protection.sv */
// Top level of the bank switch mapper with protection read port.
//
// Each request word is one bus access: a CPU register write, a CPU read of
// the protection window, a CPU program fetch or a PPU pattern fetch. Every
// request produces exactly one response word carrying the read byte, the
// masked bank number, the physical ROM address and the current mirroring.
// Register writes update the command byte, the eight bank registers or the
// mirroring bit, in request order.
// A request is registered on acceptance and its response is computed from
// that register into the output register. One word is accepted every cycle
// while rsp_chan.ready stays high; the rate is set by the single decode
// and mapping stage.
// The CSR port sets the program and pattern bank masks; write it only while
// no request is in flight.
// Reset clears all mapper state and loads the default masks. When the
// receiver stalls, the response holds; an empty input stage takes one more
// word, and req_chan.ready drops once that stage is full.
module bank_switch_mapper_with_protection (
   input  logic             clock,
   input  logic             reset,
   bsm_req_if.sink          req_chan,
   bsm_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [8:0]       csr_wr_data
);

   logic [7:0]            prg_mask_ff;
   logic [8:0]            chr_mask_ff;
   logic [7:0]            command_ff, command_in;
   logic [7:0]            bank_regs_ff [8];
   logic                  mirroring_ff, mirroring_in;
   logic                  bank_we;

   logic                  stage_valid_ff;
   bsm_pkg::req_word_type stage_word_ff;
   logic                  out_valid_ff;
   bsm_pkg::rsp_word_type out_word_ff, out_word_in;
   logic                  advance;

   logic [15:0]           addr;
   logic [12:0]           ppu_addr;
   logic [12:0]           pat_addr;
   logic [2:0]            reg_sel;
   logic [7:0]            reg_value;
   logic [7:0]            raw_bank;
   logic [7:0]            bank;

   assign advance        = stage_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_word_ff;

   assign addr      = stage_word_ff.address;
   assign ppu_addr  = addr[12:0];
   assign pat_addr  = ppu_addr ^ {command_ff[7], 12'd0};
   assign reg_value = bank_regs_ff[reg_sel];

   // Bank register that feeds the window being fetched.
   always_comb begin
      reg_sel = 3'd0;
      case (stage_word_ff.opcode)
         bsm_pkg::OP_PRG_FETCH: begin
            case (addr[14:13])
               2'd0:    reg_sel = 3'd4;
               2'd1:    reg_sel = 3'd5;
               2'd2:    reg_sel = 3'd4;
               default: reg_sel = 3'd0;
            endcase
         end
         bsm_pkg::OP_CHR_FETCH: begin
            if (!pat_addr[12]) begin
               reg_sel = pat_addr[11] ? 3'd2 : 3'd0;
            end else begin
               case (pat_addr[11:10])
                  2'd0:    reg_sel = 3'd6;
                  2'd1:    reg_sel = 3'd1;
                  2'd2:    reg_sel = 3'd7;
                  default: reg_sel = 3'd3;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      command_in   = command_ff;
      mirroring_in = mirroring_ff;
      bank_we      = 1'b0;
      raw_bank     = reg_value;
      bank         = 8'd0;
      out_word_in  = '0;

      case (stage_word_ff.opcode)
         bsm_pkg::OP_CPU_WRITE: begin
            unique case ({addr[15:13], addr[0]})
               bsm_pkg::WR_COMMAND:   command_in = stage_word_ff.write_data;
               bsm_pkg::WR_BANK:      bank_we = 1'b1;
               bsm_pkg::WR_MIRRORING: mirroring_in = ~stage_word_ff.write_data[0];
               default: ;
            endcase
         end
         bsm_pkg::OP_PROT_READ: begin
            if (addr[15:11] == bsm_pkg::PROT_WINDOW) begin
               out_word_in.read_data = (stage_word_ff.open_bus & 8'hFE)
                                     | (addr[7:0] & addr[15:8]);
            end else begin
               out_word_in.read_data = stage_word_ff.open_bus;
            end
         end
         bsm_pkg::OP_PRG_FETCH: begin
            // Swap mode trades the first and third windows.
            case (addr[14:13])
               2'd0: begin
                  raw_bank = command_ff[6] ? bsm_pkg::PRG_BANK_SECOND_LAST : reg_value;
               end
               2'd1: raw_bank = reg_value;
               2'd2: begin
                  raw_bank = command_ff[6] ? reg_value : bsm_pkg::PRG_BANK_SECOND_LAST;
               end
               default: raw_bank = bsm_pkg::PRG_BANK_LAST;
            endcase
            bank = raw_bank & prg_mask_ff;
            out_word_in.mapped_bank    = {1'b0, bank};
            out_word_in.mapped_address = {bank, addr[12:0]};
         end
         default: begin
            if (!pat_addr[12]) begin
               // Lower half: two 2K windows, mask halved.
               bank    = reg_value & chr_mask_ff[8:1];
               out_word_in.mapped_bank    = {1'b0, bank};
               out_word_in.mapped_address = {2'd0, bank, ppu_addr[10:0]};
            end else begin
               bank = reg_value & chr_mask_ff[7:0];
               out_word_in.mapped_bank    = {1'b0, bank};
               out_word_in.mapped_address = {3'd0, bank, ppu_addr[9:0]};
            end
         end
      endcase

      out_word_in.mirror_mode = mirroring_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_mask_ff    <= bsm_pkg::PRG_MASK_RESET;
         chr_mask_ff    <= bsm_pkg::CHR_MASK_RESET;
         command_ff     <= 8'd0;
         mirroring_ff   <= 1'b0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            bank_regs_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               bsm_pkg::CSR_PRG_BANK_MASK: prg_mask_ff <= csr_wr_data[7:0];
               bsm_pkg::CSR_CHR_BANK_MASK: chr_mask_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (req_chan.ready) begin
            stage_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            command_ff   <= command_in;
            mirroring_ff <= mirroring_in;
            if (bank_we) begin
               bank_regs_ff[command_ff[2:0]] <= stage_word_ff.write_data;
            end
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         stage_word_ff <= req_chan.data;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule
